### design/assert_macros.svh
// assertion macros shared by the duration parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

### design/dur_pkg.sv
// types, constants and helper functions of the duration text parser
`timescale 1ns / 1ps
`default_nettype none

package dur_pkg;

  // parser phase, one-hot
  typedef enum logic [6:0] {
    PhLead      = 7'b0000001,
    PhNum       = 7'b0000010,
    PhUnit      = 7'b0000100,
    PhWord      = 7'b0001000,
    PhTrailNum  = 7'b0010000,
    PhTrailWord = 7'b0100000,
    PhDead      = 7'b1000000
  } phase_e;

  // result status codes
  typedef enum logic [1:0] {
    StOk        = 2'd0,
    StMalformed = 2'd1,
    StOverflow  = 2'd2
  } status_e;

  // time unit codes
  typedef enum logic [1:0] {
    UnitSec  = 2'd0,
    UnitMin  = 2'd1,
    UnitHour = 2'd2,
    UnitDay  = 2'd3
  } unit_e;

  localparam int unsigned AccW    = 31;
  localparam int unsigned FactorW = 17;
  localparam int unsigned ProdW   = AccW + FactorW;

  localparam logic [AccW-1:0] MaxVal = '1;

  // character codes
  localparam logic [7:0] CharMinus = 8'h2D;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharS     = 8'h73;
  localparam logic [7:0] CharM     = 8'h6D;
  localparam logic [7:0] CharH     = 8'h68;
  localparam logic [7:0] CharD     = 8'h64;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharSpace = 8'h20;

  // lengths of the long and short keyword
  localparam logic [3:0] WordLen  = 4'd9;
  localparam logic [3:0] ShortLen = 4'd4;

  // one input word
  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  // input register to parser
  typedef struct packed {
    logic     fire;
    in_word_t word;
  } stage_t;

  // one result word
  typedef struct packed {
    logic [31:0] duration;
    status_e     status;
  } result_t;

  // characters of the keyword "permanent"
  function automatic logic [7:0] word_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = 8'h70; // p
      4'd1:    ch = 8'h65; // e
      4'd2:    ch = 8'h72; // r
      4'd3:    ch = 8'h6D; // m
      4'd4:    ch = 8'h61; // a
      4'd5:    ch = 8'h6E; // n
      4'd6:    ch = 8'h65; // e
      4'd7:    ch = 8'h6E; // n
      4'd8:    ch = 8'h74; // t
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // seconds per unit
  function automatic logic [FactorW-1:0] unit_factor(input unit_e u);
    logic [FactorW-1:0] f;
    case (u)
      UnitSec:  f = 17'd1;
      UnitMin:  f = 17'd60;
      UnitHour: f = 17'd3600;
      UnitDay:  f = 17'd86400;
      default:  f = 17'd1;
    endcase
    return f;
  endfunction

endpackage

`default_nettype wire

### design/dur_in_stage.sv
// input register of the duration parser with release control
`timescale 1ns / 1ps
`default_nettype none

module dur_in_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire dur_pkg::in_word_t word_i,
  input  wire logic             out_busy_i,
  output logic                  stall_o,
  output dur_pkg::stage_t       stage_o
);

  logic              valid_q, valid_d;
  dur_pkg::in_word_t word_q;
  logic              fire;
  logic              accept;

  // held word moves on unless it is a final byte facing a busy result register
  assign fire    = valid_q && (!word_q.last_char || !out_busy_i);
  assign stall_o = valid_q && !fire;
  assign accept  = in_valid_i && !stall_o;

  // occupancy
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fire) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_i;
    end
  end

  assign stage_o.fire = fire;
  assign stage_o.word = word_q;

endmodule

`default_nettype wire

### design/dur_parse_core.sv
// parser state and per-byte next state and result logic
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dur_parse_core (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire dur_pkg::stage_t stage_i,
  output dur_pkg::result_t     result_o
);

  dur_pkg::phase_e          phase_q, phase_d, phase_f;
  logic [dur_pkg::AccW-1:0] acc_q, acc_d, acc_f;
  logic                     minus_q, minus_d, minus_f;
  logic                     digit_q, digit_d, digit_f;
  logic                     ovf_q, ovf_d, ovf_f;
  logic [3:0]               idx_q, idx_d, idx_f;
  logic                     wsp_q, wsp_d, wsp_f;
  dur_pkg::unit_e           unit_q, unit_d, unit_f;

  logic [7:0]                  c;
  logic                        is_ws;
  logic                        is_digit;
  logic                        is_unit;
  dur_pkg::unit_e              char_unit;
  logic                        word_hit;
  logic [dur_pkg::AccW+3:0]    nv;
  logic [dur_pkg::ProdW-1:0]   prod;
  logic                        prod_big;
  logic [dur_pkg::AccW-1:0]    value;

  assign c = stage_i.word.char_code;

  // character classes
  assign is_ws    = (c inside {[dur_pkg::CharTab:dur_pkg::CharCr], dur_pkg::CharSpace});
  assign is_digit = (c inside {[dur_pkg::CharZero:dur_pkg::CharNine]});

  always_comb begin
    is_unit   = 1'b1;
    char_unit = dur_pkg::UnitSec;
    case (c)
      dur_pkg::CharS: char_unit = dur_pkg::UnitSec;
      dur_pkg::CharM: char_unit = dur_pkg::UnitMin;
      dur_pkg::CharH: char_unit = dur_pkg::UnitHour;
      dur_pkg::CharD: char_unit = dur_pkg::UnitDay;
      default:        is_unit   = 1'b0;
    endcase
  end

  // decimal accumulate: value * 10 + digit
  assign nv = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
            + {{(dur_pkg::AccW){1'b0}}, c[3:0]};

  assign word_hit = wsp_q && (idx_q < dur_pkg::WordLen) && (c == dur_pkg::word_char(idx_q));

  // state after this byte
  always_comb begin
    phase_f = phase_q;
    acc_f   = acc_q;
    minus_f = minus_q;
    digit_f = digit_q;
    ovf_f   = ovf_q;
    idx_f   = idx_q;
    wsp_f   = wsp_q;
    unit_f  = unit_q;
    if (is_ws) begin
      case (phase_q)
        dur_pkg::PhNum, dur_pkg::PhUnit: phase_f = dur_pkg::PhTrailNum;
        dur_pkg::PhWord:                 phase_f = dur_pkg::PhTrailWord;
        default:                         phase_f = phase_q;
      endcase
    end else if (phase_q inside {dur_pkg::PhTrailNum, dur_pkg::PhTrailWord, dur_pkg::PhDead}) begin
      phase_f = dur_pkg::PhDead;
    end else begin
      if (word_hit) begin
        idx_f = idx_q + 4'd1;
      end else begin
        wsp_f = 1'b0;
      end
      case (phase_q)
        dur_pkg::PhLead, dur_pkg::PhNum: begin
          if (c == dur_pkg::CharMinus && phase_q == dur_pkg::PhLead) begin
            minus_f = 1'b1;
            phase_f = dur_pkg::PhNum;
          end else if (is_digit) begin
            if (ovf_q || (nv[dur_pkg::AccW+3:dur_pkg::AccW] != 4'd0)) begin
              ovf_f = 1'b1;
            end else begin
              acc_f = nv[dur_pkg::AccW-1:0];
            end
            digit_f = 1'b1;
            phase_f = dur_pkg::PhNum;
          end else if (digit_q && is_unit) begin
            unit_f  = char_unit;
            phase_f = dur_pkg::PhUnit;
          end else begin
            phase_f = wsp_f ? dur_pkg::PhWord : dur_pkg::PhDead;
          end
        end
        dur_pkg::PhWord: begin
          if (!wsp_f) begin
            phase_f = dur_pkg::PhDead;
          end
        end
        default: phase_f = dur_pkg::PhDead;
      endcase
    end
  end

  // scaling by unit; with a nonzero unit the byte was no digit, so acc is unchanged
  assign prod     = {{(dur_pkg::FactorW){1'b0}}, acc_q}
                  * {{(dur_pkg::AccW){1'b0}}, dur_pkg::unit_factor(unit_f)};
  assign prod_big = (unit_f != dur_pkg::UnitSec)
                  && (prod[dur_pkg::ProdW-1:dur_pkg::AccW] != '0);
  assign value    = (unit_f == dur_pkg::UnitSec) ? acc_f : prod[dur_pkg::AccW-1:0];

  // result of a closed text
  always_comb begin
    result_o.duration = '1;
    result_o.status   = dur_pkg::StMalformed;
    case (phase_f)
      dur_pkg::PhWord, dur_pkg::PhTrailWord: begin
        if (wsp_f && (idx_f == dur_pkg::ShortLen || idx_f == dur_pkg::WordLen)) begin
          result_o.duration = '0;
          result_o.status   = dur_pkg::StOk;
        end
      end
      dur_pkg::PhNum, dur_pkg::PhUnit, dur_pkg::PhTrailNum: begin
        if (!digit_f) begin
          result_o.status = dur_pkg::StMalformed;
        end else if (minus_f && (acc_f != '0 || ovf_f)) begin
          result_o.status = dur_pkg::StMalformed;
        end else if (ovf_f || prod_big) begin
          result_o.status = dur_pkg::StOverflow;
        end else begin
          result_o.duration = {1'b0, value};
          result_o.status   = dur_pkg::StOk;
        end
      end
      default: result_o.status = dur_pkg::StMalformed;
    endcase
  end

  // a closed text returns the parser to its start state
  always_comb begin
    phase_d = phase_f;
    acc_d   = acc_f;
    minus_d = minus_f;
    digit_d = digit_f;
    ovf_d   = ovf_f;
    idx_d   = idx_f;
    wsp_d   = wsp_f;
    unit_d  = unit_f;
    if (stage_i.word.last_char) begin
      phase_d = dur_pkg::PhLead;
      acc_d   = '0;
      minus_d = 1'b0;
      digit_d = 1'b0;
      ovf_d   = 1'b0;
      idx_d   = 4'd0;
      wsp_d   = 1'b1;
      unit_d  = dur_pkg::UnitSec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dur_pkg::PhLead;
      acc_q   <= '0;
      minus_q <= 1'b0;
      digit_q <= 1'b0;
      ovf_q   <= 1'b0;
      idx_q   <= 4'd0;
      wsp_q   <= 1'b1;
      unit_q  <= dur_pkg::UnitSec;
    end else if (stage_i.fire) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      minus_q <= minus_d;
      digit_q <= digit_d;
      ovf_q   <= ovf_d;
      idx_q   <= idx_d;
      wsp_q   <= wsp_d;
      unit_q  <= unit_d;
    end
  end

  // checks
  `ASSERT_CLK(a_restart_after_last, stage_i.fire && stage_i.word.last_char |=> phase_q == dur_pkg::PhLead && acc_q == '0 && !ovf_q, "parser not restarted after final byte")
  `ASSERT_NEVER(a_unit_outside_unit_phase, unit_q != dur_pkg::UnitSec && (phase_q == dur_pkg::PhLead || phase_q == dur_pkg::PhNum), "unit set while digits still expected")

endmodule

`default_nettype wire

### design/dur_out_stage.sv
// result register of the duration parser
`timescale 1ns / 1ps
`default_nettype none

module dur_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire dur_pkg::result_t result_i,
  input  wire logic             out_stall_i,
  output logic                  out_valid_o,
  output dur_pkg::result_t      result_o
);

  logic             valid_q, valid_d;
  dur_pkg::result_t result_q;

  // occupancy: a load only comes when the register is empty or being taken
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

`default_nettype wire

### design/duration_string_parser.sv
// top level of the duration text parser
// result path: input register, then parser, then result register
// throughput: one byte per cycle; the input register holds back only a final
//   byte that meets a full, stalled result register
// reset: asynchronous, clears both valid flags and returns the parser to its
//   start state; payload registers are not reset
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module duration_string_parser (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         char_code_i,
  input  wire logic               last_char_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [31:0]      duration_seconds_o,
  output logic [1:0]              status_o
);

  dur_pkg::in_word_t in_word;
  dur_pkg::stage_t   stage;
  dur_pkg::result_t  result_next;
  dur_pkg::result_t  result_out;
  logic              out_busy;

  assign in_word.char_code = char_code_i;
  assign in_word.last_char = last_char_i;
  assign out_busy          = out_valid_o && out_stall_i;

  // input register
  dur_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .word_i     (in_word),
    .out_busy_i (out_busy),
    .stall_o    (in_stall_o),
    .stage_o    (stage)
  );

  // parser
  dur_parse_core u_parse_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .stage_i  (stage),
    .result_o (result_next)
  );

  // result register
  dur_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (stage.fire && stage.word.last_char),
    .result_i    (result_next),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .result_o    (result_out)
  );

  assign duration_seconds_o = $signed(result_out.duration);
  assign status_o           = result_out.status;

  // checks
  `ASSERT_CLK(a_stall_only_when_out_busy, in_stall_o |-> out_valid_o && out_stall_i, "input stalled while result register free")
  `ASSERT_CLK(a_error_gives_minus_one, out_valid_o && status_o != dur_pkg::StOk |-> duration_seconds_o == -32'sd1, "error result without -1")
  `ASSERT_CLK(a_ok_not_negative, out_valid_o && status_o == dur_pkg::StOk |-> !duration_seconds_o[31], "valid result is negative")

endmodule

`default_nettype wire
